[design/cmrq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmrq_pkg - shared types, constants and helpers of the CAN message ring queue
// Field widths, frame type and operation codes, slot word layout and the
// payload byte mask used when a data frame is stored.
// ----------------------------------------------------------------------------
package cmrq_pkg;

    // Field widths
    localparam int FUNC_W  = 1;
    localparam int TYPE_W  = 3;
    localparam int ID_W    = 29;
    localparam int LEN_W   = 4;
    localparam int DATA_W  = 64;

    // Default ring depth
    localparam int DEPTH_DEF = 16;

    // Largest payload byte count
    localparam logic [LEN_W-1:0] MAX_BYTES = 4'd8;
    localparam int               NUM_BYTES = DATA_W / 8;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_POP  = 1'b1;

    // Frame type codes
    localparam logic [TYPE_W-1:0] TYPE_NONE       = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_DATA_STD   = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_DATA_EXT   = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_REMOTE_STD = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_REMOTE_EXT = 3'd4;

    // Status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // One stored message
    typedef struct packed {
        logic [TYPE_W-1:0] msg_type;
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] data;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    function automatic logic is_data_frame(input logic [TYPE_W-1:0] t);
        return (t == TYPE_DATA_STD) || (t == TYPE_DATA_EXT);
    endfunction

    // Clamp a byte count to the payload size
    function automatic logic [LEN_W-1:0] sat_length(input logic [LEN_W-1:0] len);
        return (len > MAX_BYTES) ? MAX_BYTES : len;
    endfunction

    // Keep bytes below the (saturated) length
    function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] mask;
        mask = '0;
        for (int i = 0; i < NUM_BYTES; i++) begin
            if (LEN_W'(i) < len) begin
                mask[8*i +: 8] = 8'hFF;
            end
        end
        return mask;
    endfunction

endpackage

[design/can_message_ring_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_message_ring_queue - ring of CAN message slots with push and pop
// Each command pushes a message at the write pointer or pops one at the read
// pointer; occupancy is kept per slot.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_func and the message fields with start high; an
//   item is taken at each rising edge with start high and busy low. busy is
//   never raised, so one item can be taken in every cycle.
//   Result channel: o_done is high for exactly one cycle with o_status and the
//   popped message fields. Failed commands and pushes return zero fields.
//   Each item passes the input register, then the slot update and RAM read
//   into the result. Throughput is one item per cycle; each item touches one
//   slot and one pointer.
//   Slots live in one RAM with a registered read port; a per-slot occupied
//   flag decides success, so the RAM needs no clearing.
//   Reset (synchronous, active low) empties all slots, zeroes both pointers
//   and drops any item in flight. The receiver cannot stall: every result is
//   shown for one cycle only and must be taken then.
// ----------------------------------------------------------------------------
module can_message_ring_queue #(
    parameter int DEPTH = cmrq_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [cmrq_pkg::FUNC_W-1:0]  i_func,
    input  logic [cmrq_pkg::TYPE_W-1:0]  i_in_type,
    input  logic [cmrq_pkg::ID_W-1:0]    i_in_id,
    input  logic [cmrq_pkg::LEN_W-1:0]   i_in_length,
    input  logic [cmrq_pkg::DATA_W-1:0]  i_in_data,
    output logic                         o_done,
    output logic                         o_status,
    output logic [cmrq_pkg::TYPE_W-1:0]  o_out_type,
    output logic [cmrq_pkg::ID_W-1:0]    o_out_id,
    output logic [cmrq_pkg::LEN_W-1:0]   o_out_length,
    output logic [cmrq_pkg::DATA_W-1:0]  o_out_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // Input register
    logic                           r_b_vld;
    logic [cmrq_pkg::FUNC_W-1:0]    r_b_func;
    logic [cmrq_pkg::TYPE_W-1:0]    r_b_type;
    logic [cmrq_pkg::ID_W-1:0]      r_b_id;
    logic [cmrq_pkg::LEN_W-1:0]     r_b_len;
    logic [cmrq_pkg::DATA_W-1:0]    r_b_data;

    // Queue state
    logic [DEPTH-1:0] r_occ, n_occ;
    logic [IDX_W-1:0] r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;

    // Result register
    logic r_c_vld;
    logic r_c_status;
    logic r_c_pop;

    logic               accept;
    logic               push_ok;
    logic               pop_ok;
    logic               is_push;
    logic               is_pop;
    logic [cmrq_pkg::LEN_W-1:0] sat_len;
    cmrq_pkg::t_slot    wr_slot;
    cmrq_pkg::t_slot    rd_slot;
    logic [cmrq_pkg::SLOT_W-1:0] rd_word;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Capture the command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= accept;
        end
        if (accept) begin
            r_b_func <= i_func;
            r_b_type <= i_in_type;
            r_b_id   <= i_in_id;
            r_b_len  <= i_in_length;
            r_b_data <= i_in_data;
        end
    end

    // Decide the command against slot occupancy
    assign is_push = r_b_vld && (r_b_func == cmrq_pkg::FUNC_PUSH);
    assign is_pop  = r_b_vld && (r_b_func == cmrq_pkg::FUNC_POP);
    assign push_ok = is_push && !r_occ[r_wr_idx];
    assign pop_ok  = is_pop && r_occ[r_rd_idx];

    // Build the stored slot word
    assign sat_len          = cmrq_pkg::sat_length(r_b_len);
    assign wr_slot.msg_type = r_b_type;
    assign wr_slot.id       = r_b_id;
    assign wr_slot.length   = sat_len;
    assign wr_slot.data     = r_b_data & cmrq_pkg::byte_mask(sat_len);

    // Update occupancy and pointers
    always_comb begin
        n_occ    = r_occ;
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        if (push_ok) begin
            n_occ[r_wr_idx] = (r_b_type != cmrq_pkg::TYPE_NONE);
            n_wr_idx = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + 1'b1;
        end
        if (pop_ok) begin
            n_occ[r_rd_idx] = 1'b0;
            n_rd_idx = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + 1'b1;
        end
    end

    // Hold queue state and result flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ      <= '0;
            r_wr_idx   <= '0;
            r_rd_idx   <= '0;
            r_c_vld    <= 1'b0;
            r_c_status <= cmrq_pkg::STATUS_OK;
            r_c_pop    <= 1'b0;
        end else begin
            r_occ      <= n_occ;
            r_wr_idx   <= n_wr_idx;
            r_rd_idx   <= n_rd_idx;
            r_c_vld    <= r_b_vld;
            r_c_status <= (push_ok || pop_ok) ? cmrq_pkg::STATUS_OK
                                              : cmrq_pkg::STATUS_FAIL;
            r_c_pop    <= pop_ok;
        end
    end

    // Slot storage
    cmrq_ram #(
        .WIDTH (cmrq_pkg::SLOT_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (push_ok),
        .i_wr_addr (r_wr_idx),
        .i_wr_data (wr_slot),
        .i_rd_en   (pop_ok),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_word)
    );

    assign rd_slot = rd_word;

    // Drive the result, zero unless a pop succeeded
    assign o_done       = r_c_vld;
    assign o_status     = r_c_status;
    assign o_out_type   = r_c_pop ? rd_slot.msg_type : '0;
    assign o_out_id     = r_c_pop ? rd_slot.id : '0;
    assign o_out_length = (r_c_pop && cmrq_pkg::is_data_frame(rd_slot.msg_type))
                          ? rd_slot.length : '0;
    assign o_out_data   = (r_c_pop && cmrq_pkg::is_data_frame(rd_slot.msg_type))
                          ? rd_slot.data : '0;

    // A failed command returns an empty message
    a_fail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == cmrq_pkg::STATUS_FAIL) |->
        (o_out_type == cmrq_pkg::TYPE_NONE && o_out_id == '0 &&
         o_out_length == '0 && o_out_data == '0))
        else $error("failed command returned message fields");

    // A successful pop always returns an occupied slot
    a_pop_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_c_pop) |-> (o_out_type != cmrq_pkg::TYPE_NONE))
        else $error("pop returned an empty slot");

    // Only data frames carry a length
    a_len_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out_length != '0) |->
        (o_out_type == cmrq_pkg::TYPE_DATA_STD || o_out_type == cmrq_pkg::TYPE_DATA_EXT))
        else $error("length returned for a non-data frame");

    // Pointers stay inside the ring
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_idx <= LAST_IDX) && (r_rd_idx <= LAST_IDX))
        else $error("ring pointer out of range");

endmodule

[design/cmrq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmrq_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module cmrq_ram #(
    parameter int WIDTH = cmrq_pkg::SLOT_W,
    parameter int DEPTH = cmrq_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the CAN message ring queue
// Drives push and pop commands through the start/busy channel, predicts every
// result with a slot-level model of the ring and checks each done strobe
// field by field. Directed corner cases come first, then random phases with
// varying push/pop mix, random gaps and one pause until the queue drains.
// ----------------------------------------------------------------------------
module tb;
    import cmrq_pkg::*;

    localparam int RING_DEPTH     = DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 100;
    localparam int RANDOM_PHASES  = 22;
    localparam int PHASE_ITEMS    = 50;

    // Frame type code with no name in the package; stored as a non-data frame
    localparam logic [TYPE_W-1:0] TYPE_RESERVED = 3'd7;

    localparam logic [ID_W-1:0]   ID_MAX     = {ID_W{1'b1}};
    localparam logic [ID_W-1:0]   ID_STD_MAX = 29'h7FF;
    localparam logic [DATA_W-1:0] DATA_ONES  = {DATA_W{1'b1}};

    // One expected or observed result item
    typedef struct packed {
        logic              status;
        logic [TYPE_W-1:0] kind;
        logic [ID_W-1:0]   ident;
        logic [LEN_W-1:0]  count;
        logic [DATA_W-1:0] payload;
    } queue_result_t;

    // ------------------------------------------------------------------------
    // Ring model and result checker
    // ------------------------------------------------------------------------
    class ring_queue_scoreboard;
        logic [TYPE_W-1:0] slot_kind    [RING_DEPTH];
        logic [ID_W-1:0]   slot_ident   [RING_DEPTH];
        logic [LEN_W-1:0]  slot_count   [RING_DEPTH];
        logic [DATA_W-1:0] slot_payload [RING_DEPTH];
        int                wr_ptr;
        int                rd_ptr;
        queue_result_t     expected_results[$];
        int                mismatch_count;

        function new();
            for (int i = 0; i < RING_DEPTH; i++) begin
                slot_kind[i]    = TYPE_NONE;
                slot_ident[i]   = '0;
                slot_count[i]   = '0;
                slot_payload[i] = '0;
            end
            wr_ptr = 0;
            rd_ptr = 0;
            mismatch_count = 0;
        endfunction

        // Keep only the bytes below the byte count
        function logic [DATA_W-1:0] keep_bytes(logic [DATA_W-1:0] d, logic [LEN_W-1:0] n);
            logic [DATA_W-1:0] kept;
            kept = '0;
            for (int b = 0; b < DATA_W / 8; b++) begin
                if (b < n) kept[8*b +: 8] = d[8*b +: 8];
            end
            return kept;
        endfunction

        function int pending_count();
            return expected_results.size();
        endfunction

        // Update the ring for one accepted item and queue its result
        function void note_command(logic [FUNC_W-1:0] f, logic [TYPE_W-1:0] k,
                                   logic [ID_W-1:0] id, logic [LEN_W-1:0] n,
                                   logic [DATA_W-1:0] d);
            queue_result_t    res;
            logic [LEN_W-1:0] clamped;
            logic [TYPE_W-1:0] held;
            res = '0;
            res.status = STATUS_OK;
            if (f == FUNC_PUSH) begin
                if (slot_kind[wr_ptr] != TYPE_NONE) begin
                    res.status = STATUS_FAIL;
                end else begin
                    slot_ident[wr_ptr] = id;
                    if (k == TYPE_DATA_STD || k == TYPE_DATA_EXT) begin
                        clamped = (n > MAX_BYTES) ? MAX_BYTES : n;
                        slot_count[wr_ptr]   = clamped;
                        slot_payload[wr_ptr] = keep_bytes(d, clamped);
                    end
                    // type none leaves the slot empty but still advances
                    slot_kind[wr_ptr] = k;
                    wr_ptr = (wr_ptr == RING_DEPTH - 1) ? 0 : wr_ptr + 1;
                end
            end else begin
                held = slot_kind[rd_ptr];
                if (held == TYPE_NONE) begin
                    res.status = STATUS_FAIL;
                end else begin
                    res.kind  = held;
                    res.ident = slot_ident[rd_ptr];
                    if (held == TYPE_DATA_STD || held == TYPE_DATA_EXT) begin
                        res.count   = slot_count[rd_ptr];
                        res.payload = keep_bytes(slot_payload[rd_ptr], slot_count[rd_ptr]);
                    end
                    slot_kind[rd_ptr]    = TYPE_NONE;
                    slot_ident[rd_ptr]   = '0;
                    slot_count[rd_ptr]   = '0;
                    slot_payload[rd_ptr] = '0;
                    rd_ptr = (rd_ptr == RING_DEPTH - 1) ? 0 : rd_ptr + 1;
                end
            end
            expected_results.push_back(res);
        endfunction

        task report_mismatch(string msg);
            if (mismatch_count < MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatch_count++;
        endtask

        // Compare one result item with the oldest expectation
        task check_result(queue_result_t got);
            queue_result_t want;
            if (expected_results.size() == 0) begin
                report_mismatch("result strobe with no item outstanding");
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status got %0b want %0b", got.status,
                                              want.status));
                if (got.kind !== want.kind)
                    report_mismatch($sformatf("type got %0d want %0d", got.kind, want.kind));
                if (got.ident !== want.ident)
                    report_mismatch($sformatf("id got %h want %h", got.ident, want.ident));
                if (got.count !== want.count)
                    report_mismatch($sformatf("length got %0d want %0d", got.count,
                                              want.count));
                if (got.payload !== want.payload)
                    report_mismatch($sformatf("data got %h want %h", got.payload,
                                              want.payload));
            end
        endtask

        task check_drained();
            if (expected_results.size() != 0)
                report_mismatch($sformatf("%0d results never arrived",
                                          expected_results.size()));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and signals
    // ------------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [FUNC_W-1:0]  i_func = FUNC_PUSH;
    logic [TYPE_W-1:0]  i_in_type = TYPE_NONE;
    logic [ID_W-1:0]    i_in_id = '0;
    logic [LEN_W-1:0]   i_in_length = '0;
    logic [DATA_W-1:0]  i_in_data = '0;
    logic               o_done;
    logic               o_status;
    logic [TYPE_W-1:0]  o_out_type;
    logic [ID_W-1:0]    o_out_id;
    logic [LEN_W-1:0]   o_out_length;
    logic [DATA_W-1:0]  o_out_data;

    ring_queue_scoreboard queue_sb;
    int                   idle_cycles = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    can_message_ring_queue #(
        .DEPTH(RING_DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_in_type    (i_in_type),
        .i_in_id      (i_in_id),
        .i_in_length  (i_in_length),
        .i_in_data    (i_in_data),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_out_type   (o_out_type),
        .o_out_id     (o_out_id),
        .o_out_length (o_out_length),
        .o_out_data   (o_out_data)
    );

    // ------------------------------------------------------------------------
    // Result monitor and watchdog
    // ------------------------------------------------------------------------
    // Check each strobed result at the edge that ends its cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            queue_sb.check_result('{o_status, o_out_type, o_out_id, o_out_length,
                                    o_out_data});
    end

    // Stop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------------
    // Present one item and hold it until taken
    task send_command(input logic [FUNC_W-1:0] f, input logic [TYPE_W-1:0] k,
                      input logic [ID_W-1:0] id, input logic [LEN_W-1:0] n,
                      input logic [DATA_W-1:0] d);
        @(negedge i_clk);
        start       <= 1'b1;
        i_func      <= f;
        i_in_type   <= k;
        i_in_id     <= id;
        i_in_length <= n;
        i_in_data   <= d;
        do @(posedge i_clk); while (busy !== 1'b0);
        queue_sb.note_command(f, k, id, n, d);
    endtask

    // Drop start for a number of cycles
    task hold_idle(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Mostly short gaps, a few long ones
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Build and send one random item with the given push share
    task send_random(input int push_pct);
        logic [FUNC_W-1:0] f;
        logic [TYPE_W-1:0] k;
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  n;
        logic [DATA_W-1:0] d;
        int                r;
        f = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
        r = $urandom_range(0, 99);
        if (r < 3)      k = TYPE_NONE;
        else if (r < 8) k = TYPE_W'($urandom_range(5, 7));
        else            k = TYPE_W'($urandom_range(1, 4));
        r = $urandom_range(0, 99);
        if (r < 5)       id = '0;
        else if (r < 10) id = ID_MAX;
        else if (r < 50) id = ID_W'($urandom_range(0, 2047));
        else             id = ID_W'($urandom);
        r = $urandom_range(0, 99);
        n = (r < 85) ? LEN_W'($urandom_range(0, 8)) : LEN_W'($urandom_range(9, 15));
        r = $urandom_range(0, 99);
        if (r < 5)      d = DATA_ONES;
        else if (r < 8) d = '0;
        else            d = {$urandom, $urandom};
        send_command(f, k, id, n, d);
    endtask

    // Stop sending until every outstanding result has come back
    task wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (queue_sb.pending_count() != 0) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int push_mix[7];
        int push_pct;
        bit no_gaps;
        push_mix = '{85, 50, 15, 70, 30, 95, 5};
        queue_sb = new();

        // Hold reset at the start, then release it
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Pop on an empty ring, then fill with each frame kind and extreme fields
        send_command(FUNC_POP, TYPE_DATA_STD, ID_MAX, 4'd8, DATA_ONES);
        send_command(FUNC_PUSH, TYPE_DATA_STD, '0, 4'd0, DATA_ONES);
        send_command(FUNC_PUSH, TYPE_DATA_EXT, ID_MAX, 4'd8, DATA_ONES);
        send_command(FUNC_PUSH, TYPE_DATA_STD, ID_STD_MAX, 4'd15, {$urandom, $urandom});
        send_command(FUNC_PUSH, TYPE_REMOTE_STD, 29'h123, 4'd5, DATA_ONES);
        send_command(FUNC_PUSH, TYPE_REMOTE_EXT, ID_MAX, 4'd8, 64'h0123_4567_89AB_CDEF);
        send_command(FUNC_PUSH, TYPE_RESERVED, ID_W'($urandom), 4'd3, DATA_ONES);
        send_command(FUNC_PUSH, TYPE_DATA_EXT, 29'h1555_5555, 4'd3, DATA_ONES);
        send_command(FUNC_PUSH, TYPE_DATA_STD, 29'h0AAA_AAAA, 4'd9, 64'h5555_AAAA_5555_AAAA);
        hold_idle(2);
        repeat (8) send_command(FUNC_POP, TYPE_NONE, '0, '0, '0);
        // Empty again: pop fails
        send_command(FUNC_POP, TYPE_NONE, '0, '0, '0);
        // Type none leaves a hole that blocks the read side
        send_command(FUNC_PUSH, TYPE_NONE, ID_MAX, 4'd8, DATA_ONES);
        send_command(FUNC_PUSH, TYPE_DATA_STD, 29'h42, 4'd1, 64'hFFFF_FFFF_FFFF_FFA5);
        send_command(FUNC_POP, TYPE_NONE, '0, '0, '0);
        send_command(FUNC_PUSH, TYPE_W'(5), 29'h7, 4'd2, DATA_ONES);
        send_command(FUNC_PUSH, TYPE_W'(6), 29'h0, 4'd0, '0);
        wait_drained();

        // Random phases with shifting push/pop mix
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            push_pct = push_mix[p % 7];
            no_gaps  = (p % 4 == 3);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_random(push_pct);
                if (!no_gaps) hold_idle(pick_gap());
            end
            if (p == RANDOM_PHASES / 2) wait_drained();
        end

        // Let the last results arrive
        @(negedge i_clk);
        start <= 1'b0;
        while (queue_sb.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        queue_sb.check_drained();

        if (queue_sb.mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
design/cmrq_pkg.sv
design/cmrq_ram.sv
design/can_message_ring_queue.sv
test/tb.sv
